/* rtl/fenwick_prefix_sum_table_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the Fenwick prefix-sum table unit
// Concurrent assertion wrappers; they become empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FENWICK_PREFIX_SUM_TABLE_UNIT_ASSERT_SVH
`define FENWICK_PREFIX_SUM_TABLE_UNIT_ASSERT_SVH

`ifndef SYNTH
// Checked only while the synchronous active-low reset is released.
`define FPST_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("fpst assertion failed");
// Checked on every clock edge, reset included.
`define FPST_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("fpst assertion failed");
`else
`define FPST_ASSERT(label, clk, rst_n, prop)
`define FPST_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

/* rtl/fpst_pkg.sv */
// ----------------------------------------------------------------------------
// Fenwick prefix-sum table package
// Shared widths, command codes, state type and the item struct.
// ----------------------------------------------------------------------------
package fpst_pkg;

    localparam int unsigned IdxW  = 11;
    localparam int unsigned DataW = 32;
    localparam int unsigned CmdW  = 2;
    // A walk position reaches at most twice the largest size, 2047 * 2.
    localparam int unsigned PosW  = 12;
    // Largest size the register can express.
    localparam int unsigned SizeMax = 2047;

    localparam logic [CmdW-1:0] CMD_ADD   = 2'd0;
    localparam logic [CmdW-1:0] CMD_QUERY = 2'd1;
    localparam logic [CmdW-1:0] CMD_CLEAR = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD,
        ST_QUERY,
        ST_SEND,
        ST_CLEAR
    } t_state;

    typedef struct packed {
        logic [CmdW-1:0]         cmd;
        logic [IdxW-1:0]         index;
        logic signed [DataW-1:0] delta;
    } t_item;

endpackage

/* rtl/fpst_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module fpst_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/fpst_core.sv */
// ----------------------------------------------------------------------------
// Fenwick walk sequencer
// Runs add, query and clear walks over the cell memory, one item at a time.
// ----------------------------------------------------------------------------
`include "fenwick_prefix_sum_table_unit_assert.svh"

module fpst_core #(
    parameter int unsigned MAX_ENTRIES = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_item_valid,
    output logic                        o_item_ready,
    input  fpst_pkg::t_item             i_item,
    input  logic [fpst_pkg::PosW-1:0]   i_size,
    output logic                        o_res_valid,
    input  logic                        i_res_ready,
    output logic [fpst_pkg::DataW-1:0]  o_res_sum
);

    localparam int unsigned AddrW = $clog2(MAX_ENTRIES);
    localparam int unsigned PosW  = fpst_pkg::PosW;
    localparam int unsigned DataW = fpst_pkg::DataW;

    fpst_pkg::t_state   r_state, n_state;
    logic [PosW-1:0]    r_pos, n_pos;
    logic [DataW-1:0]   r_acc, n_acc;
    logic [DataW-1:0]   r_delta;
    logic               r_pend, n_pend;
    logic [AddrW-1:0]   r_wr_addr, n_wr_addr;
    logic [AddrW-1:0]   r_clr, n_clr;

    logic               ram_wr_en;
    logic [AddrW-1:0]   ram_wr_addr;
    logic [DataW-1:0]   ram_wr_data;
    logic               ram_rd_en;
    logic [AddrW-1:0]   ram_rd_addr;
    logic [DataW-1:0]   ram_rd_data;

    logic [PosW-1:0]    idx_ext;
    logic [PosW-1:0]    pos_lsb;
    logic [AddrW-1:0]   pos_addr;
    logic               accept;

    assign idx_ext  = {1'b0, i_item.index};
    assign pos_lsb  = r_pos & (~r_pos + 1'b1);
    // Position p lives at address p - 1.
    assign pos_addr = AddrW'(r_pos - 1'b1);
    assign accept   = i_item_valid && o_item_ready;

    fpst_ram #(
        .WIDTH (DataW),
        .DEPTH (MAX_ENTRIES)
    ) u_cells (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fpst_pkg::ST_CLEAR;
            r_pend  <= 1'b0;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos     <= n_pos;
        r_acc     <= n_acc;
        r_wr_addr <= n_wr_addr;
        if (accept) begin
            r_delta <= i_item.delta;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_pos        = r_pos;
        n_acc        = r_acc;
        n_pend       = 1'b0;
        n_wr_addr    = r_wr_addr;
        n_clr        = r_clr;
        ram_wr_en    = 1'b0;
        ram_wr_addr  = r_wr_addr;
        ram_wr_data  = ram_rd_data + r_delta;
        ram_rd_en    = 1'b0;
        ram_rd_addr  = pos_addr;
        o_item_ready = 1'b0;
        o_res_valid  = 1'b0;

        unique case (r_state)
            fpst_pkg::ST_IDLE: begin
                o_item_ready = 1'b1;
                if (i_item_valid) begin
                    unique case (i_item.cmd)
                        fpst_pkg::CMD_ADD: begin
                            if (i_item.index != '0 && idx_ext <= i_size) begin
                                n_pos   = idx_ext;
                                n_state = fpst_pkg::ST_ADD;
                            end
                        end
                        fpst_pkg::CMD_QUERY: begin
                            n_pos   = (idx_ext > i_size) ? i_size : idx_ext;
                            n_acc   = '0;
                            n_state = fpst_pkg::ST_QUERY;
                        end
                        fpst_pkg::CMD_CLEAR: begin
                            n_clr   = '0;
                            n_state = fpst_pkg::ST_CLEAR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            fpst_pkg::ST_ADD: begin
                // Write back the cell read last cycle while reading the next one;
                // the walk climbs, so the two addresses never meet.
                ram_wr_en = r_pend;
                if (r_pos <= i_size) begin
                    ram_rd_en = 1'b1;
                    n_pend    = 1'b1;
                    n_wr_addr = pos_addr;
                    n_pos     = r_pos + pos_lsb;
                end else begin
                    n_state = fpst_pkg::ST_IDLE;
                end
            end
            fpst_pkg::ST_QUERY: begin
                if (r_pend) begin
                    n_acc = r_acc + ram_rd_data;
                end
                if (r_pos != '0) begin
                    ram_rd_en = 1'b1;
                    n_pend    = 1'b1;
                    n_pos     = r_pos & (r_pos - 1'b1);
                end else begin
                    n_state = fpst_pkg::ST_SEND;
                end
            end
            fpst_pkg::ST_SEND: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = fpst_pkg::ST_IDLE;
                end
            end
            fpst_pkg::ST_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = r_clr;
                ram_wr_data = '0;
                n_clr       = r_clr + 1'b1;
                if (r_clr == AddrW'(MAX_ENTRIES - 1)) begin
                    n_state = fpst_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = fpst_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_res_sum = r_acc;

    `FPST_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> r_state == fpst_pkg::ST_CLEAR)
    `FPST_ASSERT(a_no_rw_collision, i_clk, i_rst_n, ram_wr_en && ram_rd_en |-> ram_wr_addr != ram_rd_addr)
    `FPST_ASSERT(a_clear_starts, i_clk, i_rst_n, accept && i_item.cmd == fpst_pkg::CMD_CLEAR |=> r_state == fpst_pkg::ST_CLEAR && r_clr == '0)
    `FPST_ASSERT(a_query_sends, i_clk, i_rst_n, r_state == fpst_pkg::ST_QUERY && r_pos == '0 |=> o_res_valid)

endmodule

/* rtl/fenwick_prefix_sum_table_unit.sv */
// An add walks up through the cells it touches, reading each cell and writing
// it back with the delta; a query walks down over its cells and then hands its
// result over. One item is taken at a time, for as long as its walk lasts; the
// add walk reads one cell while it writes back the one read before.
// After reset the block runs the same clearing pass as a clear command, with
// no item accepted; size resets to 1024.
// ----------------------------------------------------------------------------
// Fenwick prefix-sum table unit
// Binary indexed tree of signed 32-bit cells with add, prefix query and clear.
// ----------------------------------------------------------------------------
module fenwick_prefix_sum_table_unit #(
    parameter int unsigned MAX_ENTRIES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: size in use, written whenever the enable is high.
    input  logic        i_cfg_wr_en,
    input  logic [10:0] i_cfg_wr_data,
    // Input items.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // tdata fields from bit 0: index [10:0], delta [42:11], zero fill [47:43].
    input  logic [47:0] i_s_axis_tdata,
    // tuser fields from bit 0: command [1:0].
    input  logic [1:0]  i_s_axis_tuser,
    // Result items.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // tdata fields from bit 0: prefix_sum [31:0].
    output logic [31:0] o_m_axis_tdata
);

    localparam int unsigned PosW  = fpst_pkg::PosW;
    localparam int unsigned DataW = fpst_pkg::DataW;
    localparam int unsigned IdxW  = fpst_pkg::IdxW;
    // The usable size never exceeds the table depth nor the register range.
    localparam int unsigned SizeCap =
        (MAX_ENTRIES > fpst_pkg::SizeMax) ? fpst_pkg::SizeMax : MAX_ENTRIES;

    logic [IdxW-1:0]    r_size;
    logic [PosW-1:0]    eff_size;
    fpst_pkg::t_item    item;
    logic               res_valid;
    logic               res_ready;
    logic [DataW-1:0]   res_sum;
    logic               r_out_valid;
    logic [DataW-1:0]   r_out_data;

    // Size register; reset value is the full 1024-entry range.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= IdxW'(1024);
        end else if (i_cfg_wr_en) begin
            r_size <= i_cfg_wr_data;
        end
    end

    // The effective size saturates at the table depth. A size of zero makes
    // every add fall out of range and every query clamp to position zero.
    assign eff_size = ({1'b0, r_size} > PosW'(SizeCap)) ? PosW'(SizeCap) : {1'b0, r_size};

    assign item.cmd   = i_s_axis_tuser;
    assign item.index = i_s_axis_tdata[IdxW-1:0];
    assign item.delta = i_s_axis_tdata[IdxW+DataW-1:IdxW];

    fpst_core #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (i_s_axis_tvalid),
        .o_item_ready (o_s_axis_tready),
        .i_item       (item),
        .i_size       (eff_size),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res_sum    (res_sum)
    );

    // Output register: a finished sum parks here so the sequencer can take the
    // next item while the downstream side stalls.
    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out_data <= res_sum;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule
